// ----- hw/rtl/esu_pkg.sv -----
// ----------------------------------------------------------------------------
// esu_pkg: shared types and constants for the escape sequence unescaper
// Holds the decode mode, the queue entry format and the classification
// functions used by the front end.
// ----------------------------------------------------------------------------
package esu_pkg;

  typedef enum logic [1:0] {
    ModePlain = 2'd0,
    ModeEsc   = 2'd1,
    ModeHex   = 2'd2
  } mode_e;

  localparam int unsigned MaxBytes = 4;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChBel       = 8'h07;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChFf        = 8'h0c;
  localparam logic [7:0] ChLf        = 8'h0a;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChVt        = 8'h0b;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;

  localparam logic [2:0] DigitsX = 3'd2;
  localparam logic [2:0] DigitsU = 3'd4;

  // One decoded group of bytes; last applies to the final byte of the group.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     last;
  } entry_t;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      cnt;
  } utf8_t;

  typedef struct packed {
    logic       known;
    logic [7:0] value;
  } esc_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic esc_t esc_map(logic [7:0] c);
    esc_t r;
    r.known = 1'b1;
    case (c)
      8'h61:       r.value = ChBel;
      8'h62:       r.value = ChBs;
      8'h66:       r.value = ChFf;
      8'h6e:       r.value = ChLf;
      8'h72:       r.value = ChCr;
      8'h74:       r.value = ChTab;
      8'h76:       r.value = ChVt;
      8'h30:       r.value = ChNul;
      ChDquote:    r.value = ChDquote;
      ChSquote:    r.value = ChSquote;
      ChBackslash: r.value = ChBackslash;
      default: begin
        r.known = 1'b0;
        r.value = ChNul;
      end
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(logic [15:0] v);
    utf8_t r;
    r.b = '0;
    if (v == 16'd0) begin
      r.cnt = 2'd0;
    end else if (v < 16'h0080) begin
      r.cnt  = 2'd1;
      r.b[0] = v[7:0];
    end else if (v < 16'h0800) begin
      r.cnt  = 2'd2;
      r.b[0] = {3'b110, v[10:6]};
      r.b[1] = {2'b10, v[5:0]};
    end else begin
      r.cnt  = 2'd3;
      r.b[0] = {4'b1110, v[15:12]};
      r.b[1] = {2'b10, v[11:6]};
      r.b[2] = {2'b10, v[5:0]};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/esu_front.sv -----
// ----------------------------------------------------------------------------
// esu_front: input classifier and escape state machine
// Accepts one raw byte per beat, tracks the escape state and produces one
// group of up to four decoded bytes per beat for the queue.
// ----------------------------------------------------------------------------
module esu_front import esu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] hex_q, hex_d;
  logic [2:0]  left_q, left_d;
  logic        accept;

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && !full_i;
  assign push_o          = accept && (entry_o.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      hex_q  <= '0;
      left_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      left_q <= left_d;
    end
  end

  always_comb begin
    logic [7:0]  c;
    esc_t        esc;
    hex_t        dig;
    utf8_t       u;
    logic [15:0] hex_new;
    c       = s_axis_tdata_i;
    esc     = esc_map(c);
    dig     = hex_digit(c);
    hex_new = {hex_q[11:0], dig.value};
    u       = utf8_encode(hex_q);
    mode_d  = mode_q;
    hex_d   = hex_q;
    left_d  = left_q;
    entry_o = '0;

    if (s_axis_tlast_i) begin
      if (mode_q == ModeEsc) begin
        entry_o.bytes[entry_o.cnt[1:0]] = ChBackslash;
        entry_o.cnt = entry_o.cnt + 3'd1;
      end else if (mode_q == ModeHex) begin
        for (int i = 0; i < 3; i++) begin
          if (i < int'(u.cnt)) begin
            entry_o.bytes[entry_o.cnt[1:0]] = u.b[i];
            entry_o.cnt = entry_o.cnt + 3'd1;
          end
        end
      end
      entry_o.bytes[entry_o.cnt[1:0]] = ChNul;
      entry_o.cnt  = entry_o.cnt + 3'd1;
      entry_o.last = 1'b1;
      mode_d = ModePlain;
      hex_d  = '0;
      left_d = '0;
    end else begin
      case (mode_q)
        ModeEsc: begin
          mode_d = ModePlain;
          if (c == ChX || c == ChU) begin
            mode_d = ModeHex;
            hex_d  = '0;
            left_d = (c == ChX) ? DigitsX : DigitsU;
          end else if (esc.known) begin
            entry_o.bytes[0] = esc.value;
            entry_o.cnt      = 3'd1;
          end else begin
            entry_o.bytes[0] = ChBackslash;
            entry_o.bytes[1] = c;
            entry_o.cnt      = 3'd2;
          end
        end
        ModeHex: begin
          if (dig.valid) begin
            hex_d  = hex_new;
            left_d = left_q - 3'd1;
            if (left_d == 3'd0) begin
              u = utf8_encode(hex_new);
              for (int i = 0; i < 3; i++) begin
                if (i < int'(u.cnt)) begin
                  entry_o.bytes[entry_o.cnt[1:0]] = u.b[i];
                  entry_o.cnt = entry_o.cnt + 3'd1;
                end
              end
              mode_d = ModePlain;
              hex_d  = '0;
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (i < int'(u.cnt)) begin
                entry_o.bytes[entry_o.cnt[1:0]] = u.b[i];
                entry_o.cnt = entry_o.cnt + 3'd1;
              end
            end
            hex_d  = '0;
            left_d = '0;
            if (c == ChBackslash) begin
              mode_d = ModeEsc;
            end else begin
              mode_d = ModePlain;
              entry_o.bytes[entry_o.cnt[1:0]] = c;
              entry_o.cnt = entry_o.cnt + 3'd1;
            end
          end
        end
        default: begin
          if (c == ChBackslash) begin
            mode_d = ModeEsc;
          end else begin
            mode_d = ModePlain;
            entry_o.bytes[0] = c;
            entry_o.cnt      = 3'd1;
          end
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/esu_fifo.sv -----
// ----------------------------------------------------------------------------
// esu_fifo: short queue of decoded byte groups
// Decouples the front end from the output side so that each can stall
// on its own.
// ----------------------------------------------------------------------------
module esu_fifo import esu_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- hw/rtl/esu_back.sv -----
// ----------------------------------------------------------------------------
// esu_back: output serialiser
// Walks the head group of the queue one byte per beat into a registered
// stream output.
// ----------------------------------------------------------------------------
module esu_back import esu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  entry_t     entry_i,
  output logic       pop_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       load, is_final;

  assign load     = !empty_i && (!valid_q || m_axis_tready_i);
  assign is_final = ({1'b0, idx_q} + 3'd1) == entry_i.cnt;
  assign pop_o    = load && is_final;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_final ? 2'd0 : idx_q + 2'd1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= entry_i.bytes[idx_q];
      last_q <= entry_i.last && is_final;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

// ----- hw/rtl/escape_sequence_unescaper_core.sv -----
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_core: streaming backslash escape decoder
// Decodes C-style escapes, including hex and UTF-8 producing forms, from a
// byte stream and ends each string with a zero byte marked last.
// ----------------------------------------------------------------------------
// The block accepts one input beat per cycle whenever its four-entry queue
// has room. Each input beat yields zero to four output bytes, and the output
// side delivers one byte per cycle while the sink is ready, so the sustained
// input rate is one beat per cycle while each beat decodes to at most one
// byte; a beat that decodes to several bytes holds the output serialiser for
// each of them in turn, and the queue absorbs such bursts. Input tlast marks
// the end of a string: it carries no byte, flushes any pending escape and
// produces a zero byte with tlast set. Groups pass the queue, then the output register.
module escape_sequence_unescaper_core import esu_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  entry_t push_entry, head_entry;
  logic   push, pop, full, empty;

  esu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .full_i          (full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  esu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  esu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .entry_i         (head_entry),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- test/tb_escape_sequence_unescaper_core.sv -----
// ----------------------------------------------------------------------------
// tb_escape_sequence_unescaper_core: self-checking bench for the unescaper
// Walks a short table of escaped text with hand-written expectations where
// they are obvious, then a long run of random escape sequences. Every input
// beat is decoded by a local model and each output beat is compared with the
// oldest decoded byte, under random stalls on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_escape_sequence_unescaper_core;
  import esu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems  = 122;
  localparam int unsigned LongHold   = 50;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRows    = 28;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // A row of text; where typed is set, cnt bytes b0 and b1 are the known result.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } text_row_t;

  localparam text_row_t DirectedText [NumRows] = '{
    '{8'h00,       1'b1, 1'b1, 2'd1, ChNul,       8'h00},
    '{8'hff,       1'b0, 1'b1, 2'd1, 8'hff,       8'h00},
    '{ChBackslash, 1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{"n",         1'b0, 1'b1, 2'd1, ChLf,        8'h00},
    '{ChBackslash, 1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{"0",         1'b0, 1'b1, 2'd1, ChNul,       8'h00},
    '{ChBackslash, 1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{"q",         1'b0, 1'b1, 2'd2, ChBackslash, "q"},
    '{ChBackslash, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChU,         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"D",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"8",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"0",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"0",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChBackslash, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChX,         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"g",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChBackslash, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChX,         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"F",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChBackslash, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{8'hff,       1'b1, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChBackslash, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{ChU,         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"7",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"F",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{"f",         1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{8'h00,       1'b1, 1'b0, 2'd0, 8'h00,       8'h00}
  };

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic       m_tready = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  out_beat_t   decoded_q [$];
  out_beat_t   step_bytes [$];
  mode_e       dec_mode = ModePlain;
  logic [15:0] hex_acc = '0;
  logic [2:0]  hex_left = '0;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  logic        gaps_on = 1'b1;
  logic        hold_req = 1'b0;

  escape_sequence_unescaper_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [7:0] in_byte
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [7:0] out_byte
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void put_byte(logic [7:0] b, logic l);
    out_beat_t o;
    o.data = b;
    o.last = l;
    step_bytes.push_back(o);
  endfunction

  function automatic void put_utf8(logic [15:0] v);
    if (v == 16'h0000) begin
      return;
    end
    if (v < 16'h0080) begin
      put_byte(v[7:0], 1'b0);
    end else if (v < 16'h0800) begin
      put_byte(8'hc0 | 8'(v >> 6), 1'b0);
      put_byte(8'h80 | 8'(v & 16'h003f), 1'b0);
    end else begin
      put_byte(8'he0 | 8'(v >> 12), 1'b0);
      put_byte(8'h80 | 8'((v >> 6) & 16'h003f), 1'b0);
      put_byte(8'h80 | 8'(v & 16'h003f), 1'b0);
    end
  endfunction

  // Digit value, or 16 where the byte is no hex digit.
  function automatic logic [4:0] hex_value_of(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= "0" && c <= "9") begin
      return 5'(c - "0");
    end
    if (lc >= "a" && lc <= "f") begin
      return 5'(lc - "a" + 8'd10);
    end
    return 5'd16;
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c == ChBackslash) begin
      dec_mode = ModeEsc;
    end else begin
      dec_mode = ModePlain;
      put_byte(c, 1'b0);
    end
  endfunction

  function automatic void unescape_step(logic [7:0] c, logic eos);
    logic [4:0] d;
    logic [7:0] mapped;
    logic       known;
    step_bytes.delete();
    if (eos) begin
      if (dec_mode == ModeEsc) begin
        put_byte(ChBackslash, 1'b0);
      end else if (dec_mode == ModeHex) begin
        put_utf8(hex_acc);
      end
      put_byte(ChNul, 1'b1);
      dec_mode = ModePlain;
      hex_acc  = '0;
      hex_left = '0;
      return;
    end
    case (dec_mode)
      ModeEsc: begin
        dec_mode = ModePlain;
        known    = 1'b1;
        mapped   = c;
        case (c)
          "a": mapped = ChBel;
          "b": mapped = ChBs;
          "f": mapped = ChFf;
          "n": mapped = ChLf;
          "r": mapped = ChCr;
          "t": mapped = ChTab;
          "v": mapped = ChVt;
          "0": mapped = ChNul;
          ChDquote, ChSquote, ChBackslash: mapped = c;
          ChX, ChU: begin
            dec_mode = ModeHex;
            hex_acc  = '0;
            hex_left = (c == ChX) ? DigitsX : DigitsU;
            return;
          end
          default: known = 1'b0;
        endcase
        if (known) begin
          put_byte(mapped, 1'b0);
        end else begin
          put_byte(ChBackslash, 1'b0);
          take_plain(c);
        end
      end
      ModeHex: begin
        d = hex_value_of(c);
        if (d < 5'd16) begin
          hex_acc  = {hex_acc[11:0], d[3:0]};
          hex_left = hex_left - 3'd1;
          if (hex_left == 3'd0) begin
            put_utf8(hex_acc);
            dec_mode = ModePlain;
            hex_acc  = '0;
          end
        end else begin
          put_utf8(hex_acc);
          hex_acc  = '0;
          hex_left = '0;
          take_plain(c);
        end
      end
      default: take_plain(c);
    endcase
  endfunction

  function automatic text_row_t raw_beat(logic [7:0] c, logic eos);
    text_row_t r;
    r      = '0;
    r.data = c;
    r.eos  = eos;
    return r;
  endfunction

  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) begin
      return "0" + 8'(v);
    end
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  task automatic send_beat(input text_row_t r);
    out_beat_t o;
    int unsigned k;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r.data;
    s_tlast  <= r.eos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    unescape_step(r.data, r.eos);
    if (r.typed) begin
      for (k = 0; k < r.cnt; k++) begin
        o.data = (k == 0) ? r.b0 : r.b1;
        o.last = r.eos && (k == r.cnt - 1);
        decoded_q.push_back(o);
      end
    end else begin
      foreach (step_bytes[j]) begin
        decoded_q.push_back(step_bytes[j]);
      end
    end
    items_sent++;
  endtask

  task automatic send_sequence();
    string       esc_set = "abfnrtv0\"'\\";
    int unsigned kind;
    int unsigned n;
    logic        is_u;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: send_beat(raw_beat(8'($urandom_range(0, 255)), 1'b0));
      3, 4: begin
        send_beat(raw_beat(ChBackslash, 1'b0));
        send_beat(raw_beat(esc_set[$urandom_range(0, 10)], 1'b0));
      end
      5, 6: begin
        is_u = 1'($urandom_range(0, 1));
        send_beat(raw_beat(ChBackslash, 1'b0));
        send_beat(raw_beat(is_u ? ChU : ChX, 1'b0));
        n = $urandom_range(0, is_u ? 4 : 2);
        repeat (n) send_beat(raw_beat(hex_char(), 1'b0));
      end
      7: begin
        send_beat(raw_beat(ChBackslash, 1'b0));
        send_beat(raw_beat(8'($urandom_range(0, 255)), 1'b0));
      end
      8: send_beat(raw_beat(8'($urandom_range(0, 255)), 1'b1));
      default: send_beat(raw_beat(hex_char(), 1'b0));
    endcase
  endtask

  initial begin : sender
    int unsigned k;
    logic        squeezed;
    logic        drained;
    squeezed = 1'b0;
    drained  = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    for (k = 0; k < NumRows; k++) begin
      send_beat(DirectedText[k]);
    end
    while (items_sent < NumRows + RandItems) begin
      if (!squeezed && items_sent >= NumRows + 40) begin
        squeezed = 1'b1;
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        repeat (16) send_beat(raw_beat(8'($urandom_range(0, 255)), 1'b0));
        gaps_on  = 1'b1;
      end
      if (!drained && items_sent >= NumRows + 90) begin
        drained = 1'b1;
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (decoded_q.size() != 0);
      end
      if (items_sent >= NumRows + RandItems - 30) begin
        gaps_on = 1'b0;
      end
      send_sequence();
    end
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS escape_sequence_unescaper_core");
    end else begin
      $display("FAIL escape_sequence_unescaper_core");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got data %h last %b",
                 $realtime, m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata_o !== want.data) begin
          $display("%0t: out_byte expected %h, got %h", $realtime, want.data,
                   m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last expected %b, got %b", $realtime, want.last,
                   m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL escape_sequence_unescaper_core");
    $finish;
  end

endmodule
